[hw/rtl/rbb_pkg.sv]
package rbb_pkg;

	// Default build of the block
	localparam int OUT_WIDTH_DEF   = 400;
	localparam int OUT_HEIGHT_DEF  = 240;
	localparam int SOURCE_SIDE_DEF = 512;
	localparam int LANES_DEF       = 8;

	// Field widths
	localparam int KIND_W      = 1;
	localparam int LOAD_ADDR_W = 15;
	localparam int BYTE_W      = 8;
	localparam int ROW_W       = 8;
	localparam int GROUP_W     = 6;
	localparam int COS_W       = 16;
	localparam int CTR_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Datapath widths: screen offsets, Q2.14 products and their sums
	localparam int DX_W    = 12;
	localparam int PROD_W  = 28;
	localparam int SUM_W   = 29;
	localparam int FRAC_W  = 14;

	// Tile geometry of the source store
	localparam int TILE_LOG       = 8;
	localparam int TILE_BYTES_LOG = 13;
	localparam int BIT_SEL_W      = 3;

	// Register reset values
	localparam logic signed [COS_W-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [COS_W-1:0] SIN_RESET = 16'sd0;
	localparam logic [CTR_W-1:0]        CTR_RESET = 9'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COSINE   = 2'd0,
		REG_SINE     = 2'd1,
		REG_CENTER_X = 2'd2,
		REG_CENTER_Y = 2'd3
	} rbb_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 1'b0,
		KIND_RENDER = 1'b1
	} rbb_kind_t;

	// Stage enables and store write strobe shared by all lanes
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
		logic wr;
	} rbb_ctl_t;

endpackage

[hw/rtl/rbb_ram.sv]
module rbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/rbb_lane.sv]
module rbb_lane #(
	parameter int OUT_WIDTH   = rbb_pkg::OUT_WIDTH_DEF,
	parameter int SOURCE_SIDE = rbb_pkg::SOURCE_SIDE_DEF,
	parameter int LANES       = rbb_pkg::LANES_DEF,
	parameter int LANE_IDX    = 0,
	localparam int TPS        = (SOURCE_SIDE + (1 << rbb_pkg::TILE_LOG) - 1) >> rbb_pkg::TILE_LOG,
	localparam int STORE_BYTES = TPS * TPS * (1 << rbb_pkg::TILE_BYTES_LOG),
	localparam int AW         = $clog2(STORE_BYTES)
) (
	input  logic                                   clk,
	input  rbb_pkg::rbb_ctl_t                      ctl,
	input  logic [rbb_pkg::GROUP_W-1:0]            group,
	input  logic signed [rbb_pkg::COS_W-1:0]       cos_term,
	input  logic signed [rbb_pkg::COS_W-1:0]       sin_term,
	input  logic [rbb_pkg::CTR_W-1:0]              center_x,
	input  logic [rbb_pkg::CTR_W-1:0]              center_y,
	input  logic signed [rbb_pkg::PROD_W-1:0]      cos_dy_s1,
	input  logic signed [rbb_pkg::PROD_W-1:0]      sin_dy_s1,
	input  logic [AW-1:0]                          wr_addr,
	input  logic [rbb_pkg::BYTE_W-1:0]             wr_data,
	output logic                                   pix
);

	import rbb_pkg::*;

	localparam int XW = $clog2((2 ** GROUP_W) * LANES);
	localparam int CW = $clog2(SOURCE_SIDE);
	localparam int TW = SUM_W - FRAC_W;

	// Divide by 2^14 truncating toward zero
	function automatic logic signed [TW-1:0] trunc_q14(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] adj;
		adj = v + (v[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
		return adj[SUM_W-1:FRAC_W];
	endfunction

	logic [XW-1:0]              x;
	logic signed [DX_W-1:0]     dx;
	logic signed [PROD_W-1:0]   cos_dx_d, sin_dx_d;
	logic signed [PROD_W-1:0]   cos_dx_s1, sin_dx_s1;
	logic signed [SUM_W-1:0]    cx_q14, cy_q14;
	logic signed [SUM_W-1:0]    sum_x_s2, sum_y_s2;
	logic signed [TW-1:0]       tx, ty;
	logic                       in_x, in_y;
	logic [CW-1:0]              ux, uy;
	logic [AW-1:0]              rd_addr_d, rd_addr_s3;
	logic [BIT_SEL_W-1:0]       bit_s3, bit_s4;
	logic                       inside_s3, inside_s4;
	logic [BYTE_W-1:0]          ram_q;

	// Screen column offset of this lane
	assign x  = XW'(group) * XW'(LANES) + XW'(LANE_IDX);
	assign dx = DX_W'(x) - DX_W'(OUT_WIDTH / 2);

	assign cos_dx_d = PROD_W'(cos_term) * PROD_W'(dx);
	assign sin_dx_d = PROD_W'(sin_term) * PROD_W'(dx);

	assign cx_q14 = SUM_W'({center_x, FRAC_W'(0)});
	assign cy_q14 = SUM_W'({center_y, FRAC_W'(0)});

	// Stage 1: per-lane products
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			cos_dx_s1 <= cos_dx_d;
			sin_dx_s1 <= sin_dx_d;
		end
	end

	// Stage 2: rotated source position in Q14
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			sum_x_s2 <= SUM_W'(cos_dx_s1) + SUM_W'(sin_dy_s1) + cx_q14;
			sum_y_s2 <= SUM_W'(cos_dy_s1) - SUM_W'(sin_dx_s1) + cy_q14;
		end
	end

	// Stage 3 logic: truncate, range check, tile address
	assign tx   = trunc_q14(sum_x_s2);
	assign ty   = trunc_q14(sum_y_s2);
	assign in_x = !tx[TW-1] && (tx[TW-2:0] < (TW-1)'(SOURCE_SIDE));
	assign in_y = !ty[TW-1] && (ty[TW-2:0] < (TW-1)'(SOURCE_SIDE));
	assign ux   = tx[CW-1:0];
	assign uy   = ty[CW-1:0];

	assign rd_addr_d = AW'((AW'(uy >> TILE_LOG) * AW'(TPS) + AW'(ux >> TILE_LOG))
			<< TILE_BYTES_LOG)
		+ AW'({uy[TILE_LOG-1:0], ux[TILE_LOG-1:BIT_SEL_W]});

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			rd_addr_s3 <= rd_addr_d;
			bit_s3     <= ux[BIT_SEL_W-1:0];
			inside_s3  <= in_x && in_y;
		end
	end

	// Private copy of the source store; every load writes all copies
	rbb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (ctl.wr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.en4),
		.rd_addr (rd_addr_s3),
		.rd_data (ram_q)
	);

	// Stage 4: pick the pixel out of the fetched byte, MSB leftmost
	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			bit_s4    <= bit_s3;
			inside_s4 <= inside_s3;
		end
	end

	assign pix = inside_s4 & ram_q[BIT_SEL_W'(BYTE_W - 1) - bit_s4];

endmodule

[hw/rtl/rotated_bitmap_blit.sv]
// Rotated one-bit bitmap blit. Load items (kind 0) write one byte of the tiled
// source map; render items (kind 1) return one byte of LANES screen pixels,
// each mapped back through the Q2.14 rotation about the screen and source
// centers, black outside the map. One item is taken per clock while item_stall
// is low; a render result is valid once it has passed the product, sum,
// address, store read and output registers (the first loaded at the transfer
// edge itself), and a load takes effect for every render taken after it.
// The rate is set by the store read: each lane owns a full copy of the source
// store, so LANES copies of STORE_BYTES bytes are kept and every load writes
// all of them in the same cycle. Configuration writes are always taken and
// must only be issued while no render is in flight. The store is not cleared
// at reset; reading a byte never loaded returns whatever the memory holds.
module rotated_bitmap_blit #(
	parameter int OUT_WIDTH   = rbb_pkg::OUT_WIDTH_DEF,
	parameter int OUT_HEIGHT  = rbb_pkg::OUT_HEIGHT_DEF,
	parameter int SOURCE_SIDE = rbb_pkg::SOURCE_SIDE_DEF,
	parameter int LANES       = rbb_pkg::LANES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [rbb_pkg::KIND_W-1:0]        kind,
	input  logic [rbb_pkg::LOAD_ADDR_W-1:0]   load_address,
	input  logic [rbb_pkg::BYTE_W-1:0]        load_byte,
	input  logic [rbb_pkg::ROW_W-1:0]         out_row,
	input  logic [rbb_pkg::GROUP_W-1:0]       out_group,

	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [rbb_pkg::BYTE_W-1:0]        pixel_byte,
	output logic [rbb_pkg::ROW_W-1:0]         row_echo,
	output logic [rbb_pkg::GROUP_W-1:0]       group_echo,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import rbb_pkg::*;

	localparam int TPS         = (SOURCE_SIDE + (1 << TILE_LOG) - 1) >> TILE_LOG;
	localparam int STORE_BYTES = TPS * TPS * (1 << TILE_BYTES_LOG);
	localparam int AW          = $clog2(STORE_BYTES);

	// Configuration registers
	logic signed [COS_W-1:0] cos_q, sin_q;
	logic [CTR_W-1:0]        cx_q, cy_q;

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, result_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	rbb_ctl_t ctl;

	// Item payload carried along the pipeline
	rbb_kind_t                kind_s1, kind_s2, kind_s3;
	logic [LOAD_ADDR_W-1:0]   laddr_s1, laddr_s2, laddr_s3;
	logic [BYTE_W-1:0]        lbyte_s1, lbyte_s2, lbyte_s3;
	logic [ROW_W-1:0]         row_s1, row_s2, row_s3, row_s4, row_q;
	logic [GROUP_W-1:0]       group_s1, group_s2, group_s3, group_s4, group_q;
	logic [BYTE_W-1:0]        pixel_q;

	// Row products shared by all lanes
	logic signed [DX_W-1:0]   dy;
	logic signed [PROD_W-1:0] cos_dy_s1, sin_dy_s1;

	logic                     laddr_ok;
	logic [AW-1:0]            wr_addr;
	logic [LANES-1:0]         lane_pix;

	// Configuration write channel never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
			cx_q  <= CTR_RESET;
			cy_q  <= CTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (rbb_reg_t'(cfg_index))
				REG_COSINE: begin
					cos_q <= cfg_data[COS_W-1:0];
				end
				REG_SINE: begin
					sin_q <= cfg_data[COS_W-1:0];
				end
				REG_CENTER_X: begin
					cx_q <= cfg_data[CTR_W-1:0];
				end
				REG_CENTER_Y: begin
					cy_q <= cfg_data[CTR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Per-stage ready; bubbles collapse, loads retire at stage 3
	assign rdy_out = !result_valid_q || !result_stall;
	assign rdy4    = !valid_s4 || rdy_out;
	assign rdy3    = !valid_s3 || (kind_s3 == KIND_LOAD) || rdy4;
	assign rdy2    = !valid_s2 || rdy3;
	assign rdy1    = !valid_s1 || rdy2;
	assign item_stall = !rdy1;

	// Store write happens at stage 3, in item order with the reads
	assign laddr_ok = 32'(laddr_s3) < 32'(STORE_BYTES);
	assign wr_addr  = AW'(laddr_s3);

	assign ctl.en1 = rdy1;
	assign ctl.en2 = rdy2;
	assign ctl.en3 = rdy3;
	assign ctl.en4 = rdy4;
	assign ctl.wr  = valid_s3 && (kind_s3 == KIND_LOAD) && laddr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= item_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3 && (kind_s3 == KIND_RENDER);
			end
			if (rdy_out) begin
				result_valid_q <= valid_s4;
			end
		end
	end

	// Screen row offset and its products
	assign dy = DX_W'(out_row) - DX_W'(OUT_HEIGHT / 2);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1   <= rbb_kind_t'(kind);
			laddr_s1  <= load_address;
			lbyte_s1  <= load_byte;
			row_s1    <= out_row;
			group_s1  <= out_group;
			cos_dy_s1 <= PROD_W'(cos_q) * PROD_W'(dy);
			sin_dy_s1 <= PROD_W'(sin_q) * PROD_W'(dy);
		end
		if (rdy2) begin
			kind_s2  <= kind_s1;
			laddr_s2 <= laddr_s1;
			lbyte_s2 <= lbyte_s1;
			row_s2   <= row_s1;
			group_s2 <= group_s1;
		end
		if (rdy3) begin
			kind_s3  <= kind_s2;
			laddr_s3 <= laddr_s2;
			lbyte_s3 <= lbyte_s2;
			row_s3   <= row_s2;
			group_s3 <= group_s2;
		end
		if (rdy4) begin
			row_s4   <= row_s3;
			group_s4 <= group_s3;
		end
	end

	// Lanes: one screen pixel each
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rbb_lane #(
			.OUT_WIDTH   (OUT_WIDTH),
			.SOURCE_SIDE (SOURCE_SIDE),
			.LANES       (LANES),
			.LANE_IDX    (i)
		) u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.group     (out_group),
			.cos_term  (cos_q),
			.sin_term  (sin_q),
			.center_x  (cx_q),
			.center_y  (cy_q),
			.cos_dy_s1 (cos_dy_s1),
			.sin_dy_s1 (sin_dy_s1),
			.wr_addr   (wr_addr),
			.wr_data   (lbyte_s3),
			.pix       (lane_pix[LANES-1-i])
		);
	end

	// Merge lanes into the result byte; lane 0 is the leftmost pixel
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			pixel_q <= BYTE_W'(lane_pix);
			row_q   <= row_s4;
			group_q <= group_s4;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_byte   = pixel_q;
	assign row_echo     = row_q;
	assign group_echo   = group_q;

endmodule
